FILE: hw/rtl/sha224_pkg.sv
`timescale 1ns / 1ps

package sha224_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned DIGEST_WRDS = 7;

    localparam logic [3:0] BLOCK_LAST_WORD = 4'd15;
    localparam logic [3:0] BLOCK_LEN_HI    = 4'd14;
    localparam logic [5:0] ROUND_LAST      = 6'd63;
    localparam logic [2:0] DIGEST_LAST     = 3'd6;
    localparam logic [2:0] BYTES_FULL      = 3'd4;
    localparam logic [31:0] PAD_MARK       = 32'h8000_0000;

    // sha-224 initial hash values
    localparam logic [31:0] INIT_HASH [8] = '{
        32'hc105_9ed8, 32'h367c_d507, 32'h3070_dd17, 32'hf70e_5939,
        32'hffc0_0b31, 32'h6858_1511, 32'h64f9_8fa7, 32'hbefa_4fa4
    };

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PAD    = 5'b00010,
        S_ROUND  = 5'b00100,
        S_UPDATE = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    // which padding word comes next
    typedef enum logic [1:0] {
        PK_MARK   = 2'd0,
        PK_ZERO   = 2'd1,
        PK_LEN_LO = 2'd2,
        PK_DONE   = 2'd3
    } t_pad_kind;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // round constants
    function automatic logic [31:0] round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

FILE: hw/rtl/sha224_hash_engine.sv
`timescale 1ns / 1ps

// SHA-224 engine for a byte-aligned message fed as big-endian 32-bit words on the
// slave stream; tlast marks the final word, whose valid_bytes (0 to 4) says how many
// leading bytes belong to the message. Each word is taken while the engine is idle.
// The sixteenth word of a block starts the compression, which runs one round per
// cycle through a single round unit and a 16-word shifting schedule window, then
// folds the result into the chaining hash; no word is accepted meanwhile. After the
// final word the engine pushes its padding words (up to 18) one per cycle, pausing
// while a block compresses, so one or two more blocks are compressed; it then offers
// the seven digest words on the master stream, most significant first, tlast on the
// seventh, and clears itself for the next message.
module sha224_hash_engine
    import sha224_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // message_word[31:0], valid_bytes[34:32], zero
    input  logic        i_s_axis_tlast,   // final_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero
    output logic        o_m_axis_tlast    // last_of_digest
);

    t_state      r_state, n_state;
    t_pad_kind   r_pad_kind, n_pad_kind;
    logic        r_fin, n_fin;
    logic [3:0]  r_cnt, n_cnt;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_oidx, n_oidx;
    logic [63:0] r_len, n_len;
    logic [31:0] r_chain [8];
    logic [31:0] n_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];

    logic        s_acc;
    logic        m_acc;
    logic        push_en;
    logic [31:0] push_word;
    logic [31:0] in_word;
    logic [2:0]  in_bytes;
    logic [4:0]  byte_shift;
    logic [31:0] keep_mask;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_next;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;

    // input unpacking and byte count saturation
    assign in_word    = i_s_axis_tdata[31:0];
    assign in_bytes   = (i_s_axis_tdata[34:32] > BYTES_FULL) ? BYTES_FULL
                                                             : i_s_axis_tdata[34:32];
    assign byte_shift = {in_bytes[1:0], 3'b000};
    assign keep_mask  = ~(32'hffff_ffff >> byte_shift);

    // shared round unit
    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + round_k(r_round) + r_w[0];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_next = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_pad_kind = r_pad_kind;
        n_fin      = r_fin;
        n_cnt      = r_cnt;
        n_round    = r_round;
        n_oidx     = r_oidx;
        n_len      = r_len;
        n_chain    = r_chain;
        n_v        = r_v;
        n_w        = r_w;
        push_en    = 1'b0;
        push_word  = '0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    push_en = 1'b1;
                    if (!i_s_axis_tlast) begin
                        push_word = in_word;
                        n_len     = r_len + 64'd32;
                    end else begin
                        n_fin = 1'b1;
                        n_len = r_len + {58'd0, in_bytes, 3'b000};
                        if (in_bytes == BYTES_FULL) begin
                            push_word  = in_word;
                            n_pad_kind = PK_MARK;
                        end else begin
                            push_word  = (in_word & keep_mask) | (PAD_MARK >> byte_shift);
                            n_pad_kind = PK_ZERO;
                        end
                    end
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                case (r_pad_kind)
                    PK_MARK: begin
                        push_word  = PAD_MARK;
                        n_pad_kind = PK_ZERO;
                    end
                    PK_ZERO: begin
                        if (r_cnt == BLOCK_LEN_HI) begin
                            push_word  = r_len[63:32];
                            n_pad_kind = PK_LEN_LO;
                        end else begin
                            push_word = '0;
                        end
                    end
                    PK_LEN_LO: begin
                        push_word  = r_len[31:0];
                        n_pad_kind = PK_DONE;
                    end
                    default: begin
                        push_en = 1'b0;
                    end
                endcase
            end
            S_ROUND: begin
                n_v[0] = t1 + t2;
                n_v[1] = r_v[0];
                n_v[2] = r_v[1];
                n_v[3] = r_v[2];
                n_v[4] = r_v[3] + t1;
                n_v[5] = r_v[4];
                n_v[6] = r_v[5];
                n_v[7] = r_v[6];
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_next;
                n_round = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                n_oidx = '0;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_pad_kind == PK_DONE) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (m_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == DIGEST_LAST) begin
                        n_state    = S_IDLE;
                        n_fin      = 1'b0;
                        n_cnt      = '0;
                        n_len      = '0;
                        n_pad_kind = PK_ZERO;
                        n_chain    = INIT_HASH;
                        n_oidx     = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // word push into the schedule window, compression on a full block
        if (push_en) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[15] = push_word;
            n_cnt   = r_cnt + 4'd1;
            if (r_cnt == BLOCK_LAST_WORD) begin
                n_state = S_ROUND;
                n_round = '0;
                n_v     = r_chain;
            end else begin
                n_state = n_fin ? S_PAD : S_IDLE;
            end
        end
    end

    // control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pad_kind <= PK_ZERO;
            r_fin      <= 1'b0;
            r_cnt      <= '0;
            r_round    <= '0;
            r_oidx     <= '0;
            r_len      <= '0;
            r_chain    <= INIT_HASH;
        end else begin
            r_state    <= n_state;
            r_pad_kind <= n_pad_kind;
            r_fin      <= n_fin;
            r_cnt      <= n_cnt;
            r_round    <= n_round;
            r_oidx     <= n_oidx;
            r_len      <= n_len;
            r_chain    <= n_chain;
        end
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_w <= n_w;
    end

    // stream outputs
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tlast  = (r_oidx == DIGEST_LAST);
    assign o_m_axis_tdata  = {5'd0, r_oidx, r_chain[r_oidx]};

endmodule

FILE: hw/rtl/sha224_checker.sv
`timescale 1ns / 1ps

module sha224_checker
    import sha224_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [39:0] i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // no input word taken while a digest is on offer
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while digest is offered");

    // tlast marks the seventh digest word and no other
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[34:32] == DIGEST_LAST)))
        else $error("digest tlast does not match word index");

    // digest words follow one another in order
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid && o_m_axis_tdata[34:32] == $past(o_m_axis_tdata[34:32]) + 3'd1))
        else $error("digest word index did not advance");

    // after the last digest word the engine is ready for a new message
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=>
        (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("engine not idle after the last digest word");

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled digest word changed");

endmodule

bind sha224_hash_engine sha224_checker u_sha224_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
